>>> hdl/htw_pkg.sv
// Package with the shared types and constants of the timer wheel scheduler.
`timescale 1ns / 1ps
package htw_pkg;

    localparam logic [2:0] EV_ADDED     = 3'd0;
    localparam logic [2:0] EV_FULL      = 3'd1;
    localparam logic [2:0] EV_CANCELLED = 3'd2;
    localparam logic [2:0] EV_NOT_FOUND = 3'd3;
    localparam logic [2:0] EV_EXPIRED   = 3'd4;
    localparam logic [2:0] EV_TICK_NONE = 3'd5;
    localparam logic [2:0] EV_IDLE      = 3'd6;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ONESHOT  = 2'd1;
    localparam logic [1:0] OP_PERIODIC = 2'd2;
    localparam logic [1:0] OP_CANCEL   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] delay_len;
        logic [31:0]        cancel_id;
    } htw_in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] timer_id;
        logic [6:0]  live_timers;
        logic        last_result;
    } htw_out_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } htw_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } htw_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } htw_state_t;

endpackage

>>> hdl/htw_divider.sv
// Restoring radix-2 divider that turns a delay into ticks, one quotient bit a cycle.
`timescale 1ns / 1ps
module htw_divider
    import htw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  htw_div_req_t req,
    output htw_div_rsp_t rsp
);

    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hdl/htw_table.sv
// Timer table memory with a registered read port and one write port.
`timescale 1ns / 1ps
module htw_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 128
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/hashed_timer_wheel_scheduler.sv
// Top level of the timer wheel scheduler: control sequencer, valid bits and counters.
//
//  channel | direction | payload      | beat when
//  in      | input     | htw_in_t     | in_valid && in_ready
//  out     | output    | htw_out_t    | out_valid && out_ready
//  cfg     | input     | tick length  | cfg_valid && cfg_ready
//
// An add runs the divider, writes a free table entry if there is one and then loads the
// output register with its result.
// A cancel or a tick with live timers reads every table entry in turn, processing each one
// before the next read, then gives its final result; an idle tick goes straight to emit.
// Reset clears valid bits and counters; table entries are only used while valid.
// A stalled output holds a tick scan with a pending expiry, or the final beat, while the input waits only for idle.
`timescale 1ns / 1ps
module hashed_timer_wheel_scheduler
    import htw_pkg::*;
#(
    parameter int MAX_TIMERS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  htw_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output htw_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int DW = 128;

    htw_state_t state_reg, state_next;
    htw_in_t    op_reg, op_next;
    logic [15:0] tick_reg, tick_next;
    logic [63:0] now_reg, now_next;
    logic [31:0] fresh_reg, fresh_next;
    logic [CW-1:0] live_reg, live_next;
    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [AW:0] idx_reg, idx_next;
    logic        rdv_reg, rdv_next;
    logic [31:0] ticks_reg, ticks_next;
    logic        found_reg, found_next;
    logic        any_reg, any_next;
    htw_out_t    hold_reg, hold_next;
    htw_out_t    obuf_reg, obuf_next;
    logic        ovld_reg, ovld_next;

    htw_div_req_t div_req;
    htw_div_rsp_t div_rsp;

    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] cur;
    logic [31:0] e_id;
    logic [63:0] e_dl;
    logic [31:0] e_per;
    logic        scan_done;
    logic        proc_ok;
    logic        free_found;
    logic [AW-1:0] free_idx;
    logic        out_free;

    htw_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    htw_table #(.DEPTH(MAX_TIMERS), .AW(AW), .DW(DW)) u_tab (
        .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    assign e_id  = rd_data[127:96];
    assign e_dl  = rd_data[95:32];
    assign e_per = rd_data[31:0];
    assign cur   = idx_reg[AW-1:0] - AW'(1);
    assign scan_done = (idx_reg == (AW+1)'(MAX_TIMERS)) && rdv_reg;
    assign out_free  = !ovld_reg || out_ready;
    assign proc_ok   = rdv_reg && (op_reg.opcode == OP_CANCEL || !any_reg || out_free);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ovld_reg;
    assign out_data  = obuf_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_data.opcode)
                        OP_ONESHOT, OP_PERIODIC: state_next = ST_DIV;
                        OP_CANCEL:               state_next = ST_SCAN;
                        default:                 state_next = (live_reg == '0) ? ST_EMIT
                                                                              : ST_SCAN;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done && proc_ok)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_WRITE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next    = op_reg;
        tick_next  = cfg_valid ? cfg_data : tick_reg;
        now_next   = now_reg;
        fresh_next = fresh_reg;
        live_next  = live_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        ticks_next = ticks_reg;
        found_next = found_reg;
        any_next   = any_reg;
        hold_next  = hold_reg;
        obuf_next  = obuf_reg;
        ovld_next  = ovld_reg && !out_ready;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = cur;
        wr_data    = rd_data;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = (tick_reg == '0) ? 16'd1 : tick_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next    = in_data;
                    idx_next   = '0;
                    found_next = 1'b0;
                    any_next   = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = in_data.delay_len + 32'(div_req.divisor) - 32'd1;
                    if (in_data.opcode == OP_TICK && live_reg != '0)
                    begin
                        now_next = now_reg + 64'd1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (op_reg.delay_len <= 0)
                    begin
                        ticks_next = 32'd1;
                    end
                    else if (div_rsp.quotient == '0)
                    begin
                        ticks_next = 32'd1;
                    end
                    else
                    begin
                        ticks_next = div_rsp.quotient;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rdv_reg && !proc_ok)
                begin
                    rd_addr  = cur;
                    rdv_next = 1'b1;
                end
                else if (rdv_reg)
                begin
                    if (op_reg.opcode == OP_CANCEL)
                    begin
                        if (!found_reg && valid_reg[cur] && e_id == op_reg.cancel_id)
                        begin
                            found_next      = 1'b1;
                            valid_next[cur] = 1'b0;
                            live_next       = live_reg - CW'(1);
                        end
                    end
                    else if (valid_reg[cur] && e_dl <= now_reg)
                    begin
                        if (any_reg)
                        begin
                            obuf_next = hold_reg;
                            ovld_next = 1'b1;
                        end
                        if (e_per == '0)
                        begin
                            valid_next[cur] = 1'b0;
                            live_next       = live_reg - CW'(1);
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = {e_id, e_dl + 64'(e_per), e_per};
                        end
                        hold_next = {EV_EXPIRED, e_id, 7'(live_next), 1'b0};
                        any_next  = 1'b1;
                    end
                end
                else if (idx_reg != (AW+1)'(MAX_TIMERS))
                begin
                    rd_addr  = idx_reg[AW-1:0];
                    idx_next = idx_reg + (AW+1)'(1);
                    rdv_next = 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (free_found)
                begin
                    wr_en   = 1'b1;
                    wr_addr = free_idx;
                    wr_data = {fresh_reg, now_reg + 64'(ticks_reg),
                               (op_reg.opcode == OP_PERIODIC) ? ticks_reg : 32'd0};
                    valid_next[free_idx] = 1'b1;
                    live_next  = live_reg + CW'(1);
                    fresh_next = (fresh_reg == 32'hFFFF_FFFF) ? 32'd1 : fresh_reg + 32'd1;
                    found_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovld_next = 1'b1;
                    case (op_reg.opcode)
                        OP_ONESHOT, OP_PERIODIC:
                            obuf_next = found_reg ?
                                {EV_ADDED, fresh_reg - ((fresh_reg == 32'd1) ? 32'd2 : 32'd1),
                                 7'(live_reg), 1'b1} :
                                {EV_FULL, 32'd0, 7'(live_reg), 1'b1};
                        OP_CANCEL:
                            obuf_next = found_reg ?
                                {EV_CANCELLED, op_reg.cancel_id, 7'(live_reg), 1'b1} :
                                {EV_NOT_FOUND, 32'd0, 7'(live_reg), 1'b1};
                        default:
                        begin
                            if (any_reg)
                            begin
                                obuf_next = hold_reg;
                                obuf_next.last_result = 1'b1;
                            end
                            else if (idx_reg == '0)
                                obuf_next = {EV_IDLE, 32'd0, 7'(live_reg), 1'b1};
                            else
                                obuf_next = {EV_TICK_NONE, 32'd0, 7'(live_reg), 1'b1};
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= 16'd1;
            now_reg   <= '0;
            fresh_reg <= 32'd1;
            live_reg  <= '0;
            valid_reg <= '0;
            idx_reg   <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            now_reg   <= now_next;
            fresh_reg <= fresh_next;
            live_reg  <= live_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            rdv_reg   <= rdv_next;
            found_reg <= found_next;
            any_reg   <= any_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ticks_reg <= ticks_next;
        hold_reg  <= hold_next;
        obuf_reg  <= obuf_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == CW'($countones(valid_reg)))
        else $error("live count differs from valid bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg != '0)
        else $error("fresh id is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("accepted item left no work");

endmodule

>>> sim/tb_hashed_timer_wheel_scheduler.sv
// Self-checking testbench for the timer wheel scheduler with a scoreboard class.
`timescale 1ns / 1ps
module tb_hashed_timer_wheel_scheduler;
    import htw_pkg::*;

    localparam int TIMERS = 64;
    localparam int LIMIT_CYCLES = 2000000;

    class timer_scoreboard;
        logic [15:0] tick_len;
        logic [63:0] now_tick;
        logic [31:0] fresh_id;
        int          live;
        bit          valid[TIMERS];
        logic [31:0] ident[TIMERS];
        logic [63:0] deadline[TIMERS];
        logic [31:0] period[TIMERS];
        htw_out_t    pending[$];
        int          errors;

        function void clear();
            tick_len = 16'd1;
            now_tick = '0;
            fresh_id = 32'd1;
            live = 0;
            foreach (valid[i]) valid[i] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void push(logic [2:0] kind, logic [31:0] id, bit last);
            htw_out_t r;
            r.event_kind = kind;
            r.timer_id = id;
            r.live_timers = live[6:0];
            r.last_result = last;
            pending.insert(pending.size(), r);
        endfunction

        function logic [31:0] delay_ticks(logic [31:0] d);
            logic [63:0] t;
            t = (tick_len == 0) ? 64'd1 : {48'd0, tick_len};
            if (d == 0 || d[31]) return 32'd1;
            return 32'(({32'd0, d} + t - 1) / t);
        endfunction

        function void note_input(htw_in_t it);
            logic [31:0] tk;
            int n;
            bit done;
            done = 0;
            case (it.opcode)
                OP_ONESHOT, OP_PERIODIC:
                begin
                    tk = delay_ticks(it.delay_len);
                    for (int i = 0; i < TIMERS && !done; i++)
                        if (!valid[i])
                        begin
                            valid[i] = 1;
                            ident[i] = fresh_id;
                            deadline[i] = now_tick + tk;
                            period[i] = (it.opcode == OP_PERIODIC) ? tk : 0;
                            live++;
                            push(EV_ADDED, fresh_id, 1);
                            fresh_id = (fresh_id == '1) ? 32'd1 : fresh_id + 1;
                            done = 1;
                        end
                    if (!done) push(EV_FULL, 0, 1);
                end
                OP_CANCEL:
                begin
                    for (int i = 0; i < TIMERS && !done; i++)
                        if (valid[i] && ident[i] == it.cancel_id)
                        begin
                            valid[i] = 0;
                            live--;
                            push(EV_CANCELLED, it.cancel_id, 1);
                            done = 1;
                        end
                    if (!done) push(EV_NOT_FOUND, 0, 1);
                end
                default:
                begin
                    if (live == 0) push(EV_IDLE, 0, 1);
                    else
                    begin
                        now_tick++;
                        n = 0;
                        for (int i = 0; i < TIMERS; i++)
                            if (valid[i] && deadline[i] <= now_tick)
                            begin
                                if (period[i] == 0)
                                begin
                                    valid[i] = 0;
                                    live--;
                                end
                                else deadline[i] += period[i];
                                push(EV_EXPIRED, ident[i], 0);
                                n++;
                            end
                        if (n == 0) push(EV_TICK_NONE, 0, 1);
                        else pending[pending.size() - 1].last_result = 1;
                    end
                end
            endcase
        endfunction

        function void check_result(htw_out_t got);
            htw_out_t exp;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                errors++;
                if (errors <= 10) $display("Mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    htw_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    htw_out_t    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    timer_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    longint cycles;
    logic [31:0] recent_ids[$];

    hashed_timer_wheel_scheduler #(.MAX_TIMERS(TIMERS)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) sb.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(logic [1:0] op, logic [31:0] d, logic [31:0] id);
        htw_in_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        it.opcode = op;
        it.delay_len = d;
        it.cancel_id = id;
        in_data <= it;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
    endtask

    task automatic add_timer(logic [1:0] op, logic [31:0] d);
        send_beat(op, d, 0);
        if (sb.pending.size() > 0 && sb.pending[$].event_kind == EV_ADDED)
        begin
            recent_ids.insert(recent_ids.size(), sb.pending[$].timer_id);
            if (recent_ids.size() > 40) void'(recent_ids.pop_front());
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_tick_len(logic [15:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        sb.tick_len = v;
        cfg_valid <= 0;
    endtask

    task automatic cancel_all();
        while (sb.live > 0)
        begin
            for (int i = 0; i < TIMERS; i++)
                if (sb.valid[i]) send_beat(OP_CANCEL, 0, sb.ident[i]);
        end
    endtask

    task automatic random_item();
        int r;
        logic [31:0] d;
        r = $urandom_range(99);
        case ($urandom_range(3))
            0: d = $urandom_range(1, 4 * (sb.tick_len + 1));
            1: d = $urandom;
            2: d = $urandom_range(0, 300);
            default: d = -$urandom_range(0, 5);
        endcase
        if (r < 40) send_beat(OP_TICK, $urandom, $urandom);
        else if (r < 60) add_timer(OP_ONESHOT, d);
        else if (r < 72) add_timer(OP_PERIODIC, d);
        else if (r < 90 && recent_ids.size() > 0)
            send_beat(OP_CANCEL, $urandom, recent_ids[$urandom_range(recent_ids.size() - 1)]);
        else send_beat(OP_CANCEL, $urandom, $urandom);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        cycles = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        cfg_valid = 0;
        cfg_data = 16'd1;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_beat(OP_TICK, 0, 0);
        send_beat(OP_CANCEL, 0, 0);
        send_beat(OP_CANCEL, 0, 32'hFFFF_FFFF);
        add_timer(OP_ONESHOT, 0);
        add_timer(OP_ONESHOT, 32'h8000_0000);
        add_timer(OP_PERIODIC, 32'h7FFF_FFFF);
        add_timer(OP_PERIODIC, 1);
        add_timer(OP_ONESHOT, 3);
        send_beat(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_TICK, 0, 0);
        send_beat(OP_CANCEL, 32'hFFFF_FFFF, recent_ids[2]);
        send_beat(OP_CANCEL, 0, recent_ids[2]);
        write_tick_len(16'd0);
        add_timer(OP_ONESHOT, 2);
        write_tick_len(16'hFFFF);
        add_timer(OP_PERIODIC, 32'h7FFF_FFFF);
        add_timer(OP_ONESHOT, 32'd65536);
        send_beat(OP_TICK, 0, 0);
        for (int i = 0; i < TIMERS; i++) add_timer(OP_ONESHOT, 1);
        add_timer(OP_PERIODIC, 5);
        send_beat(OP_TICK, 0, 0);
        send_beat(OP_TICK, 0, 0);
        cancel_all();
        write_tick_len(16'd1);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 28 : 0;
            for (int k = 0; k < 85; k++)
            begin
                if (k == 42)
                begin
                    if (ph == 0) drain();
                    else write_tick_len(ph == 1 ? 16'd7 : 16'd250);
                end
                random_item();
            end
            if (ph == 0) write_tick_len(16'd1000);
        end
        send_idle_pct = 0;
        for (int i = 0; i < 70; i++) add_timer(OP_ONESHOT, $urandom_range(1, 3000));
        for (int i = 0; i < 12; i++) send_beat(OP_TICK, 0, 0);

        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> hashed_timer_wheel_scheduler.f
hdl/htw_pkg.sv
hdl/htw_divider.sv
hdl/htw_table.sv
hdl/hashed_timer_wheel_scheduler.sv
sim/tb_hashed_timer_wheel_scheduler.sv
